>>> rtl/core/bldc_pkg.sv
// Package for the binary log deframer with CRC-32 check.
// Holds the sync and header constants, the parse phase codes and the shared structs.
// It has no dependencies.
`default_nettype none

package bldc_pkg;

    localparam logic [7:0] SYNC_BYTE_1      = 8'hAA;
    localparam logic [7:0] SYNC_BYTE_2      = 8'h44;
    localparam logic [7:0] SYNC_BYTE_LONG   = 8'h12;
    localparam logic [7:0] SYNC_BYTE_SHORT  = 8'h13;

    localparam int         POS_W            = 17;
    localparam logic [4:0] LONG_HDR_LEN     = 5'd28;
    localparam logic [4:0] SHORT_HDR_LEN    = 5'd12;

    localparam logic [POS_W-1:0] POS_HDR_LEN  = 17'd3;
    localparam logic [POS_W-1:0] POS_ID_LO    = 17'd4;
    localparam logic [POS_W-1:0] POS_ID_HI    = 17'd5;
    localparam logic [POS_W-1:0] POS_BLEN_LO  = 17'd8;
    localparam logic [POS_W-1:0] POS_BLEN_HI  = 17'd9;
    localparam logic [POS_W-1:0] CRC_BYTES    = 17'd4;
    localparam logic [1:0]       CRC_LAST_IDX = 2'd3;

    localparam logic [2:0] PH_SYNC1  = 3'd0;
    localparam logic [2:0] PH_SYNC2  = 3'd1;
    localparam logic [2:0] PH_SYNC3  = 3'd2;
    localparam logic [2:0] PH_HEADER = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_CRC    = 3'd5;

    localparam logic [1:0] PART_IDLE   = 2'd0;
    localparam logic [1:0] PART_HEADER = 2'd1;
    localparam logic [1:0] PART_BODY   = 2'd2;
    localparam logic [1:0] PART_CRC    = 2'd3;

    localparam int         CFG_IDX_W       = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLY    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LEN = 8'd1;
    localparam logic [31:0] POLY_RESET    = 32'hEDB88320;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    typedef struct packed {
        logic [31:0] crc_polynomial;
        logic [15:0] max_body_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [1:0]  frame_part;
        logic [15:0] payload_offset;
        logic [15:0] message_id;
        logic [15:0] body_length;
        logic        short_format;
        logic        frame_done;
        logic        crc_good;
        logic        frame_abort;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/binary_log_deframer_crc32_unit.sv
// Binary log deframer top level: byte stream in, tagged byte stream out, config write port.
// A byte held in the input register passes through the parser step into the result
// register, and moves on only when the result register is empty or being read.
// Throughput: one byte per cycle unless the output stalls; the parser step is combinational.
// Reset: synchronous, active low; clears the parser to sync hunting, empties both
// registers and returns the polynomial and maximum body length to their reset values.
// Depends on bldc_pkg and bldc_parser.
`default_nettype none

module binary_log_deframer_crc32_unit
    import bldc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [7:0] data_byte, [23:8] payload_offset,
                                             // [39:24] message_id, [55:40] body_length,
                                             // [56] short_format, [57] crc_good,
                                             // [58] frame_abort, [63:59] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] frame_part
    output logic             m_axis_tlast,   // frame_done
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    t_cfg        r_cfg;
    t_result     s_result;
    logic        s_step;

    assign s_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || s_step;
    assign o_cfg_ready   = 1'b1;

    bldc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_polynomial  <= POLY_RESET;
            r_cfg.max_body_length <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IDX_POLY) begin
                r_cfg.crc_polynomial <= i_cfg_data;
            end else if (i_cfg_index == CFG_IDX_MAX_LEN) begin
                r_cfg.max_body_length <= i_cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_step) begin
            r_out <= s_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.frame_abort, r_out.crc_good, r_out.short_format,
                            r_out.body_length, r_out.message_id, r_out.payload_offset,
                            r_out.data_byte};
    assign m_axis_tuser  = r_out.frame_part;
    assign m_axis_tlast  = r_out.frame_done;

endmodule

`default_nettype wire

>>> rtl/core/bldc_crc8.sv
// Byte-wide update of a reflected CRC-32 with a programmable polynomial.
// Eight bit shifts are unrolled into one combinational step; uses no package.
`default_nettype none

module bldc_crc8 (
    input  wire logic [31:0] i_crc,
    input  wire logic [7:0]  i_byte,
    input  wire logic [31:0] i_poly,
    output logic      [31:0] o_crc
);

    logic [31:0] s_bits;

    always_comb begin
        s_bits = {24'd0, i_crc[7:0] ^ i_byte};
        for (int i = 0; i < 8; i++) begin
            if (s_bits[0]) begin
                s_bits = {1'b0, s_bits[31:1]} ^ i_poly;
            end else begin
                s_bits = {1'b0, s_bits[31:1]};
            end
        end
        o_crc = {8'd0, i_crc[31:8]} ^ s_bits;
    end

endmodule

`default_nettype wire

>>> rtl/core/bldc_parser.sv
// Frame parser state and next-state logic for the binary log deframer.
// Depends on bldc_pkg and bldc_crc8; the tagged result for the byte is combinational.
`default_nettype none

module bldc_parser
    import bldc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    logic [2:0]       r_phase,  n_phase;
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [4:0]       r_hdr,    n_hdr;
    logic [15:0]      r_len,    n_len;
    logic [15:0]      r_id,     n_id;
    logic             r_short,  n_short;
    logic [31:0]      r_crc,    n_crc;
    logic [31:0]      r_rcrc,   n_rcrc;

    logic [31:0]      s_crc_in;
    logic [31:0]      s_crc_out;
    logic [POS_W-1:0] s_pos_inc;
    logic [POS_W-1:0] s_body_off;
    logic [POS_W-1:0] s_crc_idx;
    logic [15:0]      s_len_hi;
    logic [1:0]       s_part;
    logic [15:0]      s_offs;
    logic             s_done;
    logic             s_good;
    logic             s_abort;
    logic             s_clear;

    assign s_crc_in = (r_phase == PH_SYNC1) ? 32'd0 : r_crc;

    bldc_crc8 u_crc (
        .i_crc  (s_crc_in),
        .i_byte (i_byte),
        .i_poly (i_cfg.crc_polynomial),
        .o_crc  (s_crc_out)
    );

    assign s_pos_inc  = r_pos + 17'd1;
    assign s_body_off = r_pos - {12'd0, r_hdr};
    assign s_crc_idx  = r_pos - {12'd0, r_hdr} - {1'b0, r_len};
    assign s_len_hi   = {i_byte, r_len[7:0]};

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_hdr   = r_hdr;
        n_len   = r_len;
        n_id    = r_id;
        n_short = r_short;
        n_crc   = r_crc;
        n_rcrc  = r_rcrc;
        s_part  = PART_IDLE;
        s_offs  = 16'd0;
        s_done  = 1'b0;
        s_good  = 1'b0;
        s_abort = 1'b0;
        s_clear = 1'b0;
        case (r_phase)
            PH_SYNC1: begin
                if (i_byte == SYNC_BYTE_1) begin
                    n_hdr   = 5'd0;
                    n_len   = 16'd0;
                    n_id    = 16'd0;
                    n_short = 1'b0;
                    n_rcrc  = 32'd0;
                    n_crc   = s_crc_out;
                    n_pos   = 17'd1;
                    n_phase = PH_SYNC2;
                    s_part  = PART_HEADER;
                end
            end
            PH_SYNC2: begin
                if (i_byte == SYNC_BYTE_2) begin
                    n_crc   = s_crc_out;
                    n_pos   = 17'd2;
                    n_phase = PH_SYNC3;
                    s_part  = PART_HEADER;
                end else begin
                    s_abort = 1'b1;
                end
            end
            PH_SYNC3: begin
                if (i_byte == SYNC_BYTE_LONG || i_byte == SYNC_BYTE_SHORT) begin
                    n_short = (i_byte == SYNC_BYTE_SHORT);
                    n_hdr   = (i_byte == SYNC_BYTE_SHORT) ? SHORT_HDR_LEN : 5'd0;
                    n_crc   = s_crc_out;
                    n_pos   = 17'd3;
                    n_phase = PH_HEADER;
                    s_part  = PART_HEADER;
                end else begin
                    s_abort = 1'b1;
                end
            end
            PH_HEADER: begin
                if (r_pos == POS_HDR_LEN) begin
                    if (r_short) begin
                        if ({8'd0, i_byte} > i_cfg.max_body_length) begin
                            s_abort = 1'b1;
                        end else begin
                            n_len = {8'd0, i_byte};
                        end
                    end else begin
                        if (i_byte != {3'd0, LONG_HDR_LEN}) begin
                            s_abort = 1'b1;
                        end else begin
                            n_hdr = LONG_HDR_LEN;
                        end
                    end
                end else if (r_pos == POS_ID_LO) begin
                    n_id = {8'd0, i_byte};
                end else if (r_pos == POS_ID_HI) begin
                    n_id = {i_byte, r_id[7:0]};
                end else if (!r_short && r_pos == POS_BLEN_LO) begin
                    n_len = {8'd0, i_byte};
                end else if (!r_short && r_pos == POS_BLEN_HI) begin
                    n_len = s_len_hi;
                    if (s_len_hi > i_cfg.max_body_length) begin
                        s_abort = 1'b1;
                    end
                end
                if (!s_abort) begin
                    n_crc  = s_crc_out;
                    n_pos  = s_pos_inc;
                    s_part = PART_HEADER;
                    if (n_hdr != 5'd0 && s_pos_inc == {12'd0, n_hdr}) begin
                        n_phase = (n_len != 16'd0) ? PH_BODY : PH_CRC;
                    end
                end
            end
            PH_BODY: begin
                if (s_body_off >= {1'b0, r_len}) begin
                    s_abort = 1'b1;
                end else begin
                    n_crc  = s_crc_out;
                    n_pos  = s_pos_inc;
                    s_part = PART_BODY;
                    s_offs = s_body_off[15:0];
                    if (s_body_off + 17'd1 == {1'b0, r_len}) begin
                        n_phase = PH_CRC;
                    end
                end
            end
            PH_CRC: begin
                if (s_crc_idx >= CRC_BYTES) begin
                    s_abort = 1'b1;
                end else begin
                    n_rcrc = r_rcrc | ({24'd0, i_byte} << {s_crc_idx[1:0], 3'b000});
                    n_pos  = s_pos_inc;
                    s_part = PART_CRC;
                    if (s_crc_idx[1:0] == CRC_LAST_IDX) begin
                        s_done = 1'b1;
                        s_good = (r_crc == n_rcrc);
                    end
                end
            end
            default: begin
                s_clear = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_result.data_byte      = i_byte;
        o_result.frame_part     = s_part;
        o_result.payload_offset = s_offs;
        o_result.message_id     = (s_part != PART_IDLE) ? n_id  : 16'd0;
        o_result.body_length    = (s_part != PART_IDLE) ? n_len : 16'd0;
        o_result.short_format   = (s_part != PART_IDLE) ? n_short : 1'b0;
        o_result.frame_done     = s_done;
        o_result.crc_good       = s_good;
        o_result.frame_abort    = s_abort;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_pos   <= '0;
            r_hdr   <= '0;
            r_len   <= '0;
            r_id    <= '0;
            r_short <= 1'b0;
            r_crc   <= '0;
            r_rcrc  <= '0;
        end else if (i_step) begin
            if (s_abort || s_done || s_clear) begin
                r_phase <= PH_SYNC1;
                r_pos   <= '0;
                r_hdr   <= '0;
                r_len   <= '0;
                r_id    <= '0;
                r_short <= 1'b0;
                r_crc   <= '0;
                r_rcrc  <= '0;
            end else begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_hdr   <= n_hdr;
                r_len   <= n_len;
                r_id    <= n_id;
                r_short <= n_short;
                r_crc   <= n_crc;
                r_rcrc  <= n_rcrc;
            end
        end
    end

endmodule

`default_nettype wire
